>>> sv/sawfs_pkg.sv
// shared types and codes for the stop-and-wait frame sender
package sawfs_pkg;

  localparam int MAX_PAYLOAD_DEF = 124;
  localparam int BEAT_BYTES_DEF  = 8;
  localparam int HDR_LEN         = 4;
  localparam int CHK_LEN         = 2;
  localparam int CFG_IDX_W       = 3;

  // item commands
  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_ACK  = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_BEAT    = 2'd0;
  localparam logic [1:0] KIND_REFUSED = 2'd1;
  localparam logic [1:0] KIND_ACKED   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DATA_TYPE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_TYPE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_FLAG  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MORE_FLAG = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ERR_PER   = 3'd5;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  data_byte;
    logic        packet_last;
    logic [7:0]  ack_type;
    logic [15:0] ack_seq_first;
    logic [15:0] ack_seq_echo;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] beat_data;
    logic [3:0]  beat_bytes;
    logic        beat_last;
    logic        is_resend;
    logic [15:0] frame_seq;
  } result_t;

endpackage

>>> sv/stop_and_wait_frame_sender.sv
// stop-and-wait frame sender: framing, frame buffer, beat output and resend control
//
// Items enter on item/item_valid/item_stall: payload bytes, received acknowledgements
// and time ticks. Results leave on result/result_valid/result_stall: frame beats,
// refusals of bytes offered while a frame waits, and accepted acknowledgements.
// Registers are written over cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is
// always high.
// A payload byte that does not close a frame is written to the buffer on acceptance.
// A byte that closes a frame is followed by the header and check byte writes into the
// frame buffer (S_HDR), a buffer read (S_RD), then per beat an output load (S_LD) and,
// unless it is the last beat, a buffer read as the beat is taken (S_OUT), for
// ceil((fill+6)/BEAT_BYTES) beats. A resend skips the header writes. The single-port
// frame buffer is read one row of BEAT_BYTES bytes per access.
// A transfer on the item side happens only while no frame is being built or sent and
// the output register is empty or being taken. When the receiver stalls, the output
// register holds its beat and the beat sequence waits.
// Reset clears all control state, sets the sequence number to 1 and restores the
// register defaults. The frame buffer is not cleared; only bytes of the current
// frame are ever read.
module stop_and_wait_frame_sender #(
  parameter int MAX_PAYLOAD = sawfs_pkg::MAX_PAYLOAD_DEF,
  parameter int BEAT_BYTES  = sawfs_pkg::BEAT_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  sawfs_pkg::item_t                   item,
  output logic                               result_valid,
  input  logic                               result_stall,
  output sawfs_pkg::result_t                 result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sawfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                        cfg_data
);

  localparam int FRAME_MAX = MAX_PAYLOAD + sawfs_pkg::HDR_LEN + sawfs_pkg::CHK_LEN;
  localparam int ROWS      = (FRAME_MAX + BEAT_BYTES - 1) / BEAT_BYTES;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LANE_W    = (BEAT_BYTES > 1) ? $clog2(BEAT_BYTES) : 1;
  localparam int FILL_W    = $clog2(MAX_PAYLOAD + 1);
  localparam int LEN_W     = $clog2(FRAME_MAX + 1);

  localparam logic [ROW_W-1:0]  H0_ROW   = ROW_W'(0 / BEAT_BYTES);
  localparam logic [LANE_W-1:0] H0_LANE  = LANE_W'(0 % BEAT_BYTES);
  localparam logic [ROW_W-1:0]  H1_ROW   = ROW_W'(1 / BEAT_BYTES);
  localparam logic [LANE_W-1:0] H1_LANE  = LANE_W'(1 % BEAT_BYTES);
  localparam logic [ROW_W-1:0]  H2_ROW   = ROW_W'(2 / BEAT_BYTES);
  localparam logic [LANE_W-1:0] H2_LANE  = LANE_W'(2 % BEAT_BYTES);
  localparam logic [ROW_W-1:0]  H3_ROW   = ROW_W'(3 / BEAT_BYTES);
  localparam logic [LANE_W-1:0] H3_LANE  = LANE_W'(3 % BEAT_BYTES);
  localparam logic [ROW_W-1:0]  PAY_ROW  = ROW_W'(sawfs_pkg::HDR_LEN / BEAT_BYTES);
  localparam logic [LANE_W-1:0] PAY_LANE = LANE_W'(sawfs_pkg::HDR_LEN % BEAT_BYTES);

  localparam logic [2:0] STEP_SEQ_HI = 3'd0;
  localparam logic [2:0] STEP_SEQ_LO = 3'd1;
  localparam logic [2:0] STEP_TYPE   = 3'd2;
  localparam logic [2:0] STEP_FLAG   = 3'd3;
  localparam logic [2:0] STEP_LAST   = 3'd5;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_HDR  = 5'b00010,
    S_RD   = 5'b00100,
    S_LD   = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state;

  logic [7:0]  data_type_code;
  logic [7:0]  ack_type_code;
  logic [7:0]  end_flag_code;
  logic [7:0]  more_flag_code;
  logic [31:0] timeout_ticks;
  logic [7:0]  error_period;

  logic [FILL_W-1:0] fill_count;
  logic [7:0]        check_even;
  logic [7:0]        check_odd;
  logic [15:0]       sequence_num;
  logic              awaiting;
  logic [31:0]       tick_count;
  logic [7:0]        send_count;
  logic [ROW_W-1:0]  wr_row;
  logic [LANE_W-1:0] wr_lane;
  logic [7:0]        hdr [6];
  logic [2:0]        step;
  logic [ROW_W-1:0]  rd_row;
  logic [LEN_W-1:0]  rem;
  logic              corrupt;
  logic              resend;

  logic [BEAT_BYTES-1:0][7:0] mem [ROWS];
  logic [BEAT_BYTES-1:0][7:0] rd_q;

  logic              accept;
  logic              out_take;
  logic              res_load;
  logic              take_byte;
  logic [FILL_W-1:0] fill_inc;
  logic [7:0]        check_even_upd;
  logic [7:0]        check_odd_upd;
  logic              close_frame;
  logic [7:0]        flag_byte;
  logic              ack_match;
  logic              ack_good;
  logic              ack_bad;
  logic [31:0]       tick_inc;
  logic              tick_fire;
  logic [7:0]        send_count_inc;
  logic              corrupt_now;
  logic [LEN_W-1:0]  frame_len;

  logic              mem_we;
  logic [ROW_W-1:0]  mem_row;
  logic [LANE_W-1:0] mem_lane;
  logic [7:0]        mem_byte;
  logic              wr_adv;
  logic              rd_en;

  logic [3:0]        beat_n;
  logic              beat_end;
  logic [63:0]       beat_data;

  assign cfg_ready  = 1'b1;
  assign item_stall = !((state == S_IDLE) && (!result_valid || !result_stall));
  assign accept     = item_valid && !item_stall;
  assign out_take   = result_valid && !result_stall;

  // output register gets a new result at this edge
  assign res_load = (state == S_LD)
                  || ((state == S_IDLE) && accept
                      && (((item.cmd == sawfs_pkg::CMD_BYTE) && awaiting)
                          || ((item.cmd == sawfs_pkg::CMD_ACK) && ack_good)));

  assign take_byte      = accept && (item.cmd == sawfs_pkg::CMD_BYTE) && !awaiting;
  assign fill_inc       = fill_count + FILL_W'(1);
  assign check_even_upd = fill_count[0] ? check_even : (check_even ^ item.data_byte);
  assign check_odd_upd  = fill_count[0] ? (check_odd ^ item.data_byte) : check_odd;
  assign close_frame    = item.packet_last || (fill_inc == FILL_W'(MAX_PAYLOAD));
  assign flag_byte      = item.packet_last ? end_flag_code : more_flag_code;

  assign ack_match = awaiting && (item.ack_type == ack_type_code);
  assign ack_good  = ack_match && (item.ack_seq_first == item.ack_seq_echo);
  assign ack_bad   = ack_match && (item.ack_seq_first != item.ack_seq_echo);
  // saturating tick count, a zero timeout behaves as one
  assign tick_inc  = (tick_count != '1) ? tick_count + 32'd1 : tick_count;
  assign tick_fire = awaiting && (tick_inc >= timeout_ticks);

  assign send_count_inc = send_count + 8'd1;
  assign corrupt_now    = (error_period != 8'd0) && (send_count_inc == error_period);
  assign frame_len      = LEN_W'(fill_count)
                        + LEN_W'(sawfs_pkg::HDR_LEN + sawfs_pkg::CHK_LEN);

  // buffer write port: payload bytes in idle, header and check bytes while building
  always_comb begin
    mem_we   = 1'b0;
    mem_row  = wr_row;
    mem_lane = wr_lane;
    mem_byte = item.data_byte;
    wr_adv   = 1'b0;
    if (state == S_IDLE && take_byte) begin
      mem_we = 1'b1;
      wr_adv = 1'b1;
    end else if (state == S_HDR) begin
      mem_we   = 1'b1;
      mem_byte = hdr[step];
      unique case (step)
        STEP_SEQ_HI: begin
          mem_row  = H0_ROW;
          mem_lane = H0_LANE;
        end
        STEP_SEQ_LO: begin
          mem_row  = H1_ROW;
          mem_lane = H1_LANE;
        end
        STEP_TYPE: begin
          mem_row  = H2_ROW;
          mem_lane = H2_LANE;
        end
        STEP_FLAG: begin
          mem_row  = H3_ROW;
          mem_lane = H3_LANE;
        end
        default: begin
          // check bytes follow the payload
          wr_adv = 1'b1;
        end
      endcase
    end
  end

  assign rd_en = (state == S_RD) || ((state == S_OUT) && out_take && !result.beat_last);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_row][mem_lane] <= mem_byte;
    end
    if (rd_en) begin
      rd_q <= mem[rd_row];
    end
  end

  // beat assembly from the row just read
  assign beat_end = (rem <= LEN_W'(BEAT_BYTES));
  assign beat_n   = beat_end ? 4'(rem) : 4'(BEAT_BYTES);

  always_comb begin
    beat_data = '0;
    for (int l = 0; l < BEAT_BYTES; l++) begin
      if (4'(l) < beat_n) begin
        beat_data[8*l +: 8] = rd_q[l];
        // corrupted copy goes out only, the buffer stays clean
        if (corrupt && beat_end && (4'(l) == beat_n - 4'd1)) begin
          beat_data[8*l] = ~rd_q[l][0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      data_type_code <= 8'd1;
      ack_type_code  <= 8'd2;
      end_flag_code  <= 8'd1;
      more_flag_code <= 8'd0;
      timeout_ticks  <= 32'd100000;
      error_period   <= 8'd5;
      fill_count     <= '0;
      check_even     <= '0;
      check_odd      <= '0;
      sequence_num   <= 16'd1;
      awaiting       <= 1'b0;
      tick_count     <= '0;
      send_count     <= '0;
      wr_row         <= PAY_ROW;
      wr_lane        <= PAY_LANE;
      step           <= '0;
      rd_row         <= '0;
      rem            <= '0;
      corrupt        <= 1'b0;
      resend         <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          sawfs_pkg::REG_DATA_TYPE: data_type_code <= cfg_data[7:0];
          sawfs_pkg::REG_ACK_TYPE:  ack_type_code  <= cfg_data[7:0];
          sawfs_pkg::REG_END_FLAG:  end_flag_code  <= cfg_data[7:0];
          sawfs_pkg::REG_MORE_FLAG: more_flag_code <= cfg_data[7:0];
          sawfs_pkg::REG_TIMEOUT:   timeout_ticks  <= cfg_data;
          sawfs_pkg::REG_ERR_PER:   error_period   <= cfg_data[7:0];
          default: ;
        endcase
      end

      if (out_take && !res_load) begin
        result_valid <= 1'b0;
      end

      if (wr_adv) begin
        if (wr_lane == LANE_W'(BEAT_BYTES - 1)) begin
          wr_row  <= wr_row + ROW_W'(1);
          wr_lane <= '0;
        end else begin
          wr_lane <= wr_lane + LANE_W'(1);
        end
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (item.cmd)
              sawfs_pkg::CMD_BYTE: begin
                if (awaiting) begin
                  result_valid          <= 1'b1;
                  result.kind           <= sawfs_pkg::KIND_REFUSED;
                  result.beat_data      <= '0;
                  result.beat_bytes     <= '0;
                  result.beat_last      <= 1'b0;
                  result.is_resend      <= 1'b0;
                  result.frame_seq      <= sequence_num;
                end else begin
                  fill_count <= fill_inc;
                  if (close_frame) begin
                    hdr[0]     <= sequence_num[15:8];
                    hdr[1]     <= sequence_num[7:0];
                    hdr[2]     <= data_type_code;
                    hdr[3]     <= flag_byte;
                    hdr[4]     <= check_even_upd ^ sequence_num[15:8] ^ data_type_code;
                    hdr[5]     <= check_odd_upd ^ sequence_num[7:0] ^ flag_byte;
                    check_even <= '0;
                    check_odd  <= '0;
                    awaiting   <= 1'b1;
                    send_count <= corrupt_now ? 8'd0 : send_count_inc;
                    corrupt    <= corrupt_now;
                    resend     <= 1'b0;
                    tick_count <= '0;
                    step       <= '0;
                    state      <= S_HDR;
                  end else begin
                    check_even <= check_even_upd;
                    check_odd  <= check_odd_upd;
                  end
                end
              end
              sawfs_pkg::CMD_ACK: begin
                if (ack_good) begin
                  result_valid      <= 1'b1;
                  result.kind       <= sawfs_pkg::KIND_ACKED;
                  result.beat_data  <= '0;
                  result.beat_bytes <= '0;
                  result.beat_last  <= 1'b0;
                  result.is_resend  <= 1'b0;
                  result.frame_seq  <= sequence_num;
                  sequence_num      <= sequence_num + 16'd1;
                  awaiting          <= 1'b0;
                  fill_count        <= '0;
                  tick_count        <= '0;
                  wr_row            <= PAY_ROW;
                  wr_lane           <= PAY_LANE;
                end else if (ack_bad) begin
                  tick_count <= '0;
                  resend     <= 1'b1;
                  corrupt    <= 1'b0;
                  rd_row     <= '0;
                  rem        <= frame_len;
                  state      <= S_RD;
                end
              end
              sawfs_pkg::CMD_TICK: begin
                if (tick_fire) begin
                  tick_count <= '0;
                  resend     <= 1'b1;
                  corrupt    <= 1'b0;
                  rd_row     <= '0;
                  rem        <= frame_len;
                  state      <= S_RD;
                end else if (awaiting) begin
                  tick_count <= tick_inc;
                end
              end
              default: ;
            endcase
          end
        end
        S_HDR: begin
          step <= step + 3'd1;
          if (step == STEP_LAST) begin
            rd_row <= '0;
            rem    <= frame_len;
            state  <= S_RD;
          end
        end
        S_RD: begin
          state <= S_LD;
        end
        S_LD: begin
          result_valid      <= 1'b1;
          result.kind       <= sawfs_pkg::KIND_BEAT;
          result.beat_data  <= beat_data;
          result.beat_bytes <= beat_n;
          result.beat_last  <= beat_end;
          result.is_resend  <= resend;
          result.frame_seq  <= sequence_num;
          rd_row            <= rd_row + ROW_W'(1);
          rem               <= rem - LEN_W'(beat_n);
          state             <= S_OUT;
        end
        S_OUT: begin
          if (out_take) begin
            state <= result.beat_last ? S_IDLE : S_LD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // buffer data must never arrive while the output register is still occupied
  a_ld_out_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_LD) |-> !result_valid)
    else $error("beat load with output register full");

  a_beat_awaiting: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind == sawfs_pkg::KIND_BEAT) |-> awaiting)
    else $error("frame beat without a frame waiting");

  a_beat_size: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind == sawfs_pkg::KIND_BEAT) |->
      (result.beat_bytes != 4'd0 && result.beat_bytes <= 4'(BEAT_BYTES)))
    else $error("beat byte count out of range");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_W'(MAX_PAYLOAD))
    else $error("fill count beyond payload limit");

  a_fresh_send: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == S_HDR && state == S_RD) |-> !resend)
    else $error("newly built frame marked as resend");

endmodule

>>> dv/stop_and_wait_frame_sender_tb.sv
// self-checking testbench for the stop-and-wait frame sender with a built-in frame predictor
module stop_and_wait_frame_sender_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_LEN   = sawfs_pkg::MAX_PAYLOAD_DEF + sawfs_pkg::HDR_LEN
                             + sawfs_pkg::CHK_LEN;
  localparam int PHASE_ITEMS = 22;

  class frame_scoreboard;
    logic [7:0]  data_type;
    logic [7:0]  ack_code;
    logic [7:0]  end_flag;
    logic [7:0]  more_flag;
    logic [31:0] timeout;
    logic [7:0]  err_period;

    logic [7:0]  frame_buf [STORE_LEN];
    int unsigned fill;
    logic [7:0]  par_even;
    logic [7:0]  par_odd;
    logic [15:0] seq_no;
    bit          waiting;
    logic [31:0] ticks;
    logic [7:0]  sends;

    sawfs_pkg::result_t due_results [$];
    int          failures;
    int          n_items;
    int          n_effective;
    int          n_frames;
    int          n_resends;
    int          n_corrupt;
    int          n_refused;
    int          n_acked;
    int          n_wraps;

    function new();
      data_type  = 8'd1;
      ack_code   = 8'd2;
      end_flag   = 8'd1;
      more_flag  = 8'd0;
      timeout    = 32'd100000;
      err_period = 8'd5;
      foreach (frame_buf[i]) frame_buf[i] = 8'h00;
      fill     = 0;
      par_even = '0;
      par_odd  = '0;
      seq_no   = 16'd1;
      waiting  = 1'b0;
      ticks    = '0;
      sends    = '0;
      failures = 0;
      n_items = 0;
      n_effective = 0;
      n_frames = 0;
      n_resends = 0;
      n_corrupt = 0;
      n_refused = 0;
      n_acked = 0;
      n_wraps = 0;
    endfunction

    function void set_register(logic [sawfs_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        sawfs_pkg::REG_DATA_TYPE: data_type  = val[7:0];
        sawfs_pkg::REG_ACK_TYPE:  ack_code   = val[7:0];
        sawfs_pkg::REG_END_FLAG:  end_flag   = val[7:0];
        sawfs_pkg::REG_MORE_FLAG: more_flag  = val[7:0];
        sawfs_pkg::REG_TIMEOUT:   timeout    = val;
        sawfs_pkg::REG_ERR_PER:   err_period = val[7:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // cut the stored frame into beats
    function void queue_beats(bit corrupt, bit resend);
      int unsigned        len;
      int unsigned        pos;
      int unsigned        n;
      logic [7:0]         v;
      sawfs_pkg::result_t r;
      len = fill + sawfs_pkg::HDR_LEN + sawfs_pkg::CHK_LEN;
      pos = 0;
      while (pos < len) begin
        n = len - pos;
        if (n > sawfs_pkg::BEAT_BYTES_DEF) n = sawfs_pkg::BEAT_BYTES_DEF;
        r = '0;
        r.kind = sawfs_pkg::KIND_BEAT;
        for (int b = 0; b < n; b++) begin
          v = frame_buf[pos + b];
          // flipped check bit goes out on the wire only, the stored copy stays good
          if (corrupt && pos + b == len - 1) v = v ^ 8'h01;
          r.beat_data[8*b +: 8] = v;
        end
        pos += n;
        r.beat_bytes = 4'(n);
        r.beat_last  = (pos >= len);
        r.is_resend  = resend;
        r.frame_seq  = seq_no;
        due_results.push_back(r);
      end
      ticks = '0;
      if (resend) n_resends++;
    endfunction

    function void build_frame(bit closes);
      logic [7:0] flag;
      bit         corrupt;
      flag = closes ? end_flag : more_flag;
      frame_buf[0] = seq_no[15:8];
      frame_buf[1] = seq_no[7:0];
      frame_buf[2] = data_type;
      frame_buf[3] = flag;
      par_even ^= frame_buf[0] ^ frame_buf[2];
      par_odd  ^= frame_buf[1] ^ frame_buf[3];
      frame_buf[fill + sawfs_pkg::HDR_LEN]     = par_even;
      frame_buf[fill + sawfs_pkg::HDR_LEN + 1] = par_odd;
      par_even = '0;
      par_odd  = '0;
      waiting  = 1'b1;
      sends    = sends + 8'd1;
      corrupt  = (err_period != 8'd0) && (sends == err_period);
      if (corrupt) begin
        sends = '0;
        n_corrupt++;
      end
      n_frames++;
      queue_beats(corrupt, 1'b0);
    endfunction

    // returns 1 when the item changes state or causes a result
    function bit note_item(sawfs_pkg::item_t it);
      bit                 effect;
      sawfs_pkg::result_t r;
      effect = 1'b0;
      n_items++;
      case (it.cmd)
        sawfs_pkg::CMD_BYTE: begin
          effect = 1'b1;
          if (waiting) begin
            r = '0;
            r.kind = sawfs_pkg::KIND_REFUSED;
            r.frame_seq = seq_no;
            due_results.push_back(r);
            n_refused++;
          end else begin
            if (fill < sawfs_pkg::MAX_PAYLOAD_DEF) begin
              frame_buf[sawfs_pkg::HDR_LEN + fill] = it.data_byte;
              if (fill % 2 == 0) par_even ^= it.data_byte;
              else par_odd ^= it.data_byte;
              fill++;
            end
            if (it.packet_last || fill >= sawfs_pkg::MAX_PAYLOAD_DEF)
              build_frame(it.packet_last);
          end
        end
        sawfs_pkg::CMD_ACK: begin
          // other type codes are network-layer traffic and pass by
          if (waiting && it.ack_type == ack_code) begin
            effect = 1'b1;
            if (it.ack_seq_first == it.ack_seq_echo) begin
              r = '0;
              r.kind = sawfs_pkg::KIND_ACKED;
              r.frame_seq = seq_no;
              due_results.push_back(r);
              if (seq_no == 16'hFFFF) n_wraps++;
              seq_no  = seq_no + 16'd1;
              waiting = 1'b0;
              fill    = 0;
              ticks   = '0;
              n_acked++;
            end else begin
              queue_beats(1'b0, 1'b1);
            end
          end
        end
        sawfs_pkg::CMD_TICK: begin
          if (waiting) begin
            effect = 1'b1;
            if (ticks != '1) ticks = ticks + 32'd1;
            if (ticks >= timeout) queue_beats(1'b0, 1'b1);
          end
        end
        default: ;
      endcase
      if (effect) n_effective++;
      return effect;
    endfunction

    function void complain(string what, sawfs_pkg::result_t want, sawfs_pkg::result_t got);
      failures++;
      if (failures <= 10) begin
        $display("[%0t] %s", $time, what);
        $display("  expected kind %0d data %h bytes %0d last %0b resend %0b seq %h",
                 want.kind, want.beat_data, want.beat_bytes, want.beat_last,
                 want.is_resend, want.frame_seq);
        $display("  actual   kind %0d data %h bytes %0d last %0b resend %0b seq %h",
                 got.kind, got.beat_data, got.beat_bytes, got.beat_last,
                 got.is_resend, got.frame_seq);
      end
    endfunction

    function void check_result(sawfs_pkg::result_t got);
      sawfs_pkg::result_t want;
      if (due_results.size() == 0) begin
        complain("result with nothing outstanding", '0, got);
        return;
      end
      want = due_results.pop_front();
      if (got.kind !== want.kind || got.beat_data !== want.beat_data ||
          got.beat_bytes !== want.beat_bytes || got.beat_last !== want.beat_last ||
          got.is_resend !== want.is_resend || got.frame_seq !== want.frame_seq)
        complain("result mismatch", want, got);
    endfunction

    function void close_out();
      if (due_results.size() != 0) begin
        failures += due_results.size();
        $display("%0d outstanding results never arrived", due_results.size());
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            item_valid;
  logic                            item_stall;
  sawfs_pkg::item_t                item;
  logic                            result_valid;
  logic                            result_stall;
  sawfs_pkg::result_t              result;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [sawfs_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0]                     cfg_data;

  frame_scoreboard sb;
  int              burst_left;

  stop_and_wait_frame_sender i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
  end

  // receiver: windows of random length, each with its own stall density
  initial begin : receiver_pattern
    int span;
    int pct;
    result_stall = 1'b0;
    forever begin
      span = $urandom_range(40, 1);
      case ($urandom_range(3, 0))
        0: pct = 0;
        1: pct = 25;
        2: pct = 60;
        default: pct = 90;
      endcase
      repeat (span) begin
        @(negedge clk);
        result_stall <= ($urandom_range(99, 0) < pct);
      end
    end
  end

  function automatic sawfs_pkg::item_t noise_item();
    sawfs_pkg::item_t it;
    it.cmd           = 2'($urandom_range(3, 0));
    it.data_byte     = 8'($urandom);
    it.packet_last   = 1'($urandom);
    it.ack_type      = 8'($urandom);
    it.ack_seq_first = 16'($urandom);
    it.ack_seq_echo  = 16'($urandom);
    return it;
  endfunction

  function automatic sawfs_pkg::item_t payload_item(logic [7:0] data, logic last);
    sawfs_pkg::item_t it;
    it = noise_item();
    it.cmd = sawfs_pkg::CMD_BYTE;
    it.data_byte = data;
    it.packet_last = last;
    return it;
  endfunction

  function automatic sawfs_pkg::item_t ack_item(logic [7:0] code, logic [15:0] first,
                                                logic [15:0] echo);
    sawfs_pkg::item_t it;
    it = noise_item();
    it.cmd = sawfs_pkg::CMD_ACK;
    it.ack_type = code;
    it.ack_seq_first = first;
    it.ack_seq_echo = echo;
    return it;
  endfunction

  function automatic sawfs_pkg::item_t tick_item();
    sawfs_pkg::item_t it;
    it = noise_item();
    it.cmd = sawfs_pkg::CMD_TICK;
    return it;
  endfunction

  // returns right after the accepting edge; the next call drives at the following negedge
  task automatic send_item(input sawfs_pkg::item_t it);
    int gap;
    gap = 0;
    if (burst_left <= 0) begin
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
      burst_left = $urandom_range(16, 1);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    void'(sb.note_item(it));
  endtask

  task automatic wait_results_clear(input int settle);
    int guard;
    guard = 0;
    @(negedge clk);
    item_valid <= 1'b0;
    while (sb.pending() != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(input logic [sawfs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(idx, val);
  endtask

  task automatic load_settings(input logic [7:0] dtype, input logic [7:0] acode,
                               input logic [7:0] eflag, input logic [7:0] mflag,
                               input logic [31:0] tmo, input logic [7:0] period);
    wait_results_clear(20);
    write_reg(sawfs_pkg::REG_DATA_TYPE, 32'(dtype));
    write_reg(sawfs_pkg::REG_ACK_TYPE, 32'(acode));
    write_reg(sawfs_pkg::REG_END_FLAG, 32'(eflag));
    write_reg(sawfs_pkg::REG_MORE_FLAG, 32'(mflag));
    write_reg(sawfs_pkg::REG_TIMEOUT, tmo);
    write_reg(sawfs_pkg::REG_ERR_PER, 32'(period));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // disturb a waiting frame a little, then release it with a good acknowledgement
  task automatic answer_frame();
    int          k;
    logic [15:0] s;
    k = ($urandom_range(1, 0) == 0) ? 0 : $urandom_range(4, 1);
    repeat (k) begin
      s = 16'($urandom);
      case ($urandom_range(3, 0))
        0: send_item(payload_item(8'($urandom), 1'($urandom)));
        1: repeat ($urandom_range(7, 1)) send_item(tick_item());
        2: send_item(ack_item(sb.ack_code ^ 8'($urandom_range(255, 1)), s, s));
        default: send_item(ack_item(sb.ack_code, s, s ^ 16'($urandom_range(65535, 1))));
      endcase
    end
    s = 16'($urandom);
    send_item(ack_item(sb.ack_code, s, s));
  endtask

  task automatic run_packet(input int len);
    for (int i = 0; i < len; i++) begin
      send_item(payload_item(8'($urandom), i == len - 1));
      if (sb.waiting) answer_frame();
    end
  endtask

  task automatic random_phase(input int quota);
    int stop_at;
    int len;
    stop_at = sb.n_items + quota;
    while (sb.n_items < stop_at) begin
      if ($urandom_range(9, 0) < 7) begin
        len = ($urandom_range(7, 0) == 0) ? $urandom_range(24, 13) : $urandom_range(12, 1);
        run_packet(len);
      end else begin
        repeat ($urandom_range(3, 1)) send_item(noise_item());
      end
      // now and then hold the sender back until the receiver has caught up
      if ($urandom_range(9, 0) == 0) wait_results_clear(0);
    end
  endtask

  initial begin : stimulus
    sb = new();
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, reset register values
    send_item(tick_item());
    send_item(ack_item(sb.ack_code, 16'hFFFF, 16'hFFFF));
    send_item('1);
    send_item(payload_item(8'h00, 1'b0));
    send_item(payload_item(8'hFF, 1'b1));
    send_item(payload_item(8'hA5, 1'b0));
    send_item(ack_item(8'hFF, 16'h0000, 16'h0000));
    send_item(ack_item(sb.ack_code, 16'h0000, 16'hFFFF));
    send_item(tick_item());
    send_item(ack_item(sb.ack_code, 16'hFFFF, 16'hFFFF));
    for (int i = 0; i < 9; i++) send_item(payload_item(8'(8'h11 * i), i == 8));
    send_item(ack_item(sb.ack_code, 16'h0000, 16'h0000));
    random_phase(PHASE_ITEMS);

    // data type and more flag 0x00, ack type and end flag 0xFF, one-tick timeout, error period one
    load_settings(8'h00, 8'hFF, 8'hFF, 8'h00, 32'd1, 8'd1);
    send_item(payload_item(8'h5A, 1'b1));
    send_item(tick_item());
    send_item(ack_item(sb.ack_code, 16'h1234, 16'h1234));
    random_phase(PHASE_ITEMS);

    // data type and more flag 0xFF, ack type and end flag 0x00, timeout never reached, corruption off
    load_settings(8'hFF, 8'h00, 8'h00, 8'hFF, 32'hFFFF_FFFF, 8'd0);
    random_phase(PHASE_ITEMS);

    load_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  32'($urandom_range(6, 2)), 8'($urandom_range(7, 2)));
    random_phase(PHASE_ITEMS);

    load_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  32'hFFFF_FFFF, 8'd255);
    random_phase(PHASE_ITEMS);

    wait_results_clear(50);
    sb.close_out();
    $display("run took %0d items, %0d acted on: %0d frames, %0d resends, %0d flipped checks",
             sb.n_items, sb.n_effective, sb.n_frames, sb.n_resends, sb.n_corrupt);
    $display("%0d bytes refused while waiting, %0d acks taken, sequence rolled over %0d time(s)",
             sb.n_refused, sb.n_acked, sb.n_wraps);
    if (sb.failures == 0) begin
      $display("stop_and_wait_frame_sender verification clean");
    end else begin
      $display("stop_and_wait_frame_sender verification failed");
    end
    $finish;
  end

  initial begin : run_limit
    #20_000_000;
    $display("stop_and_wait_frame_sender verification failed");
    $finish;
  end

endmodule

>>> sim.f
sv/sawfs_pkg.sv
sv/stop_and_wait_frame_sender.sv
dv/stop_and_wait_frame_sender_tb.sv
